FILE: rtl/fdsc_pkg.sv
package fdsc_pkg;

    localparam int FIFO_W      = 48;
    localparam int LEVEL_W     = 3;
    localparam int LEN_W       = 14;
    localparam int WD_W        = 15;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WD_W-1:0]    WATCHDOG_LIMIT = WD_W'(20000);
    localparam logic [15:0]        SYNC_RESET     = 16'h4489;
    localparam logic [LEVEL_W-1:0] FIFO_FULL      = LEVEL_W'(6);
    localparam logic [LEVEL_W-1:0] WORD_ROOM      = LEVEL_W'(4);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SLOT  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_WAIT  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_WRITE = 2'd3;

    localparam logic CFG_SYNC_WORD = 1'b0;
    localparam logic CFG_AUTO_SYNC = 1'b1;

    typedef struct packed {
        logic               disk_write_valid;
        logic [7:0]         disk_write_byte;
        logic               mem_write_valid;
        logic [15:0]        mem_write_word;
        logic               sync_irq;
        logic               block_irq;
        logic [1:0]         dma_state;
        logic [LEVEL_W-1:0] fifo_level;
        logic               last;
    } result_t;

    // A drain job expands into one disk byte per FIFO byte in the back end.
    typedef struct packed {
        logic               drain;
        result_t            res;
        logic [FIFO_W-1:0]  drain_bytes;
        logic [LEVEL_W-1:0] drain_count;
    } job_t;

endpackage

FILE: rtl/fdsc_front.sv
module fdsc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [7:0]                        s_disk_byte,
    input  logic [15:0]                       s_mem_word,
    input  logic [fdsc_pkg::LEN_W-1:0]        s_length,
    input  logic                              s_to_disk,
    input  logic                              s_wait_sync,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              q_full,
    output logic                              job_push,
    output fdsc_pkg::job_t                    job
);

    logic [15:0]                      sync_word_reg;
    logic                             auto_sync_reg;
    logic [fdsc_pkg::FIFO_W-1:0]      fifo_bytes_reg, fifo_bytes_next;
    logic [fdsc_pkg::LEVEL_W-1:0]     fifo_fill_reg, fifo_fill_next;
    logic [1:0]                       mode_reg, mode_next;
    logic [fdsc_pkg::LEN_W-1:0]       words_left_reg, words_left_next;
    logic [fdsc_pkg::WD_W-1:0]        watchdog_reg, watchdog_next;
    logic                             accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign job_push  = accept;

    always_comb begin
        logic [fdsc_pkg::LEVEL_W-1:0] kept;
        logic [fdsc_pkg::LEVEL_W-1:0] pushed_fill;
        logic [fdsc_pkg::FIFO_W-1:0]  pushed_bytes;
        logic [fdsc_pkg::LEVEL_W-1:0] idx;
        logic [fdsc_pkg::LEN_W-1:0]   wl_dec;
        logic                         hit;

        fifo_bytes_next = fifo_bytes_reg;
        fifo_fill_next  = fifo_fill_reg;
        mode_next       = mode_reg;
        words_left_next = words_left_reg;
        watchdog_next   = watchdog_reg;
        job             = '0;
        hit             = 1'b0;
        kept            = '0;
        pushed_fill     = '0;
        pushed_bytes    = '0;
        idx             = '0;
        wl_dec          = words_left_reg - fdsc_pkg::LEN_W'(1);

        unique case (s_command)
            fdsc_pkg::CMD_TICK: begin
                if (mode_reg != fdsc_pkg::MODE_WRITE) begin
                    // A full FIFO loses its oldest word before the new byte goes in.
                    kept = (fifo_fill_reg >= fdsc_pkg::FIFO_FULL) ?
                           fifo_fill_reg - fdsc_pkg::LEVEL_W'(2) : fifo_fill_reg;
                    pushed_fill  = kept + fdsc_pkg::LEVEL_W'(1);
                    pushed_bytes = {fifo_bytes_reg[fdsc_pkg::FIFO_W-9:0], s_disk_byte};
                    fifo_bytes_next = pushed_bytes;
                    fifo_fill_next  = pushed_fill;
                    if (pushed_fill >= fdsc_pkg::LEVEL_W'(2)) begin
                        for (int i = 0; i < 8; i++) begin
                            if (pushed_bytes[i +: 16] == sync_word_reg) begin
                                hit = 1'b1;
                            end
                        end
                    end
                    if (!hit && auto_sync_reg) begin
                        watchdog_next = watchdog_reg + fdsc_pkg::WD_W'(1);
                        hit = watchdog_reg > fdsc_pkg::WATCHDOG_LIMIT;
                    end
                    if (hit) begin
                        if (mode_reg == fdsc_pkg::MODE_WAIT) begin
                            mode_next       = fdsc_pkg::MODE_READ;
                            fifo_bytes_next = '0;
                            fifo_fill_next  = '0;
                        end
                        watchdog_next = '0;
                    end
                    job.res.sync_irq = hit;
                end else if (fifo_fill_reg != '0) begin
                    idx = fifo_fill_reg - fdsc_pkg::LEVEL_W'(1);
                    fifo_fill_next = idx;
                    job.res.disk_write_valid = 1'b1;
                    job.res.disk_write_byte  = 8'(fifo_bytes_reg >> {idx, 3'b000});
                end
            end
            fdsc_pkg::CMD_SLOT: begin
                if (words_left_reg != '0 && mode_reg == fdsc_pkg::MODE_READ &&
                    fifo_fill_reg >= fdsc_pkg::LEVEL_W'(2)) begin
                    idx = fifo_fill_reg - fdsc_pkg::LEVEL_W'(2);
                    fifo_fill_next  = idx;
                    words_left_next = wl_dec;
                    job.res.mem_write_valid = 1'b1;
                    job.res.mem_write_word  = 16'(fifo_bytes_reg >> {idx, 3'b000});
                    if (wl_dec == '0) begin
                        mode_next         = fdsc_pkg::MODE_OFF;
                        job.res.block_irq = 1'b1;
                    end
                end else if (words_left_reg != '0 && mode_reg == fdsc_pkg::MODE_WRITE &&
                             fifo_fill_reg <= fdsc_pkg::WORD_ROOM) begin
                    pushed_bytes    = {fifo_bytes_reg[fdsc_pkg::FIFO_W-17:0], s_mem_word};
                    pushed_fill     = fifo_fill_reg + fdsc_pkg::LEVEL_W'(2);
                    fifo_bytes_next = pushed_bytes;
                    fifo_fill_next  = pushed_fill;
                    words_left_next = wl_dec;
                    if (wl_dec == '0) begin
                        // The whole FIFO goes out to disk; the back end spreads it
                        // over one transaction per byte.
                        job.drain       = 1'b1;
                        job.drain_bytes = pushed_bytes;
                        job.drain_count = pushed_fill;
                        fifo_fill_next  = '0;
                        mode_next       = fdsc_pkg::MODE_OFF;
                    end
                end
            end
            fdsc_pkg::CMD_START: begin
                fifo_bytes_next = '0;
                fifo_fill_next  = '0;
                words_left_next = s_length;
                if (s_length == '0) begin
                    mode_next = fdsc_pkg::MODE_OFF;
                end else if (s_to_disk) begin
                    mode_next = fdsc_pkg::MODE_WRITE;
                end else begin
                    mode_next = s_wait_sync ? fdsc_pkg::MODE_WAIT : fdsc_pkg::MODE_READ;
                end
            end
            fdsc_pkg::CMD_STOP: begin
                mode_next       = fdsc_pkg::MODE_OFF;
                words_left_next = '0;
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase

        job.res.dma_state  = mode_next;
        job.res.fifo_level = fifo_fill_next;
        job.res.last       = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg  <= fdsc_pkg::SYNC_RESET;
            auto_sync_reg  <= 1'b0;
            fifo_bytes_reg <= '0;
            fifo_fill_reg  <= '0;
            mode_reg       <= fdsc_pkg::MODE_OFF;
            words_left_reg <= '0;
            watchdog_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    fdsc_pkg::CFG_SYNC_WORD: sync_word_reg <= cfg_data;
                    fdsc_pkg::CFG_AUTO_SYNC: auto_sync_reg <= cfg_data[0];
                    default: auto_sync_reg <= auto_sync_reg;
                endcase
            end
            if (accept) begin
                fifo_bytes_reg <= fifo_bytes_next;
                fifo_fill_reg  <= fifo_fill_next;
                mode_reg       <= mode_next;
                words_left_reg <= words_left_next;
                watchdog_reg   <= watchdog_next;
            end
        end
    end

endmodule

FILE: rtl/fdsc_queue.sv
module fdsc_queue #(
    parameter int DEPTH = fdsc_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fdsc_pkg::job_t push_job,
    input  logic           pop,
    output fdsc_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fdsc_pkg::job_t   slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/fdsc_back.sv
module fdsc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  fdsc_pkg::job_t    q_job,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output fdsc_pkg::result_t m_res
);

    logic                             m_valid_reg;
    fdsc_pkg::result_t                res_reg, res_next;
    logic                             drain_active_reg, drain_active_next;
    logic [fdsc_pkg::FIFO_W-1:0]      drain_bytes_reg;
    logic [fdsc_pkg::LEVEL_W-1:0]     drain_left_reg;
    logic [fdsc_pkg::LEVEL_W-1:0]     sel_left;
    logic [fdsc_pkg::LEVEL_W-1:0]     new_left;
    logic [fdsc_pkg::FIFO_W-1:0]      drain_src;
    fdsc_pkg::result_t                drain_res;
    logic                             out_free;
    logic                             load;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = out_free && !drain_active_reg && !q_empty;
    assign load     = out_free && (drain_active_reg || !q_empty);
    assign m_valid  = m_valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        sel_left  = drain_active_reg ? drain_left_reg : q_job.drain_count;
        drain_src = drain_active_reg ? drain_bytes_reg : q_job.drain_bytes;
        new_left  = sel_left - fdsc_pkg::LEVEL_W'(1);

        // Oldest byte first; the transfer turns off with the final byte.
        drain_res                  = '0;
        drain_res.disk_write_valid = 1'b1;
        drain_res.disk_write_byte  = 8'(drain_src >> {new_left, 3'b000});
        drain_res.block_irq        = !drain_active_reg;
        drain_res.dma_state        = (new_left == '0) ? fdsc_pkg::MODE_OFF :
                                                        fdsc_pkg::MODE_WRITE;
        drain_res.fifo_level       = new_left;
        drain_res.last             = (new_left == '0);

        if (drain_active_reg || q_job.drain) begin
            res_next          = drain_res;
            drain_active_next = (new_left != '0);
        end else begin
            res_next          = q_job.res;
            drain_active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            drain_active_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg      <= load;
            if (load) begin
                drain_active_reg <= drain_active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg        <= res_next;
            drain_left_reg <= new_left;
            if (!drain_active_reg) begin
                drain_bytes_reg <= q_job.drain_bytes;
            end
        end
    end

endmodule

FILE: rtl/floppy_dma_fifo_sync_controller.sv
// Disk DMA controller with a six-byte FIFO and sync-mark detection.
// Input transactions (s_valid/s_ready) carry a command: a disk-byte tick, a DMA
// slot, a transfer start or a stop. Each gives one result transaction on
// m_valid/m_ready, except the DMA slot that ends a write transfer, which
// sends every FIFO byte to disk as a run of two to six results, the final one
// marked by m_last.
// The front end updates the FIFO, counters and mode in the cycle a command is
// accepted and queues a result job; the back end turns jobs into results.
// A result is registered in the job queue and then in the output register. One
// command is taken per cycle while the queue has room; a write drain occupies
// the output register with one result per byte, and the job queue (QUEUE_DEPTH
// entries) absorbs commands meanwhile. When the receiver stalls, the output
// register holds and s_ready drops once the queue fills.
// The configuration channel (cfg_valid/cfg_ready) is always ready: index 0
// sets the sync word, index 1 the auto-sync enable.
// Synchronous reset clears the FIFO, mode, word count and watchdog, restores
// the default sync word and empties the queue; the block is ready straight away.
module floppy_dma_fifo_sync_controller #(
    parameter int QUEUE_DEPTH = fdsc_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [7:0]                    s_disk_byte,
    input  logic [15:0]                   s_mem_word,
    input  logic [fdsc_pkg::LEN_W-1:0]    s_length,
    input  logic                          s_to_disk,
    input  logic                          s_wait_sync,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_disk_write_valid,
    output logic [7:0]                    m_disk_write_byte,
    output logic                          m_mem_write_valid,
    output logic [15:0]                   m_mem_write_word,
    output logic                          m_sync_irq,
    output logic                          m_block_irq,
    output logic [1:0]                    m_dma_state,
    output logic [fdsc_pkg::LEVEL_W-1:0]  m_fifo_level,
    output logic                          m_last
);

    fdsc_pkg::job_t    push_job;
    fdsc_pkg::job_t    head_job;
    fdsc_pkg::result_t res;
    logic              job_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;

    fdsc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_disk_byte (s_disk_byte),
        .s_mem_word  (s_mem_word),
        .s_length    (s_length),
        .s_to_disk   (s_to_disk),
        .s_wait_sync (s_wait_sync),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .job_push    (job_push),
        .job         (push_job)
    );

    fdsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    fdsc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_job   (head_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_disk_write_valid = res.disk_write_valid;
    assign m_disk_write_byte  = res.disk_write_byte;
    assign m_mem_write_valid  = res.mem_write_valid;
    assign m_mem_write_word   = res.mem_write_word;
    assign m_sync_irq         = res.sync_irq;
    assign m_block_irq        = res.block_irq;
    assign m_dma_state        = res.dma_state;
    assign m_fifo_level       = res.fifo_level;
    assign m_last             = res.last;

endmodule
